// ===== rtl/ppt_pkg.sv =====
// Shared types and constants for the piece progress tracker.
`default_nettype none

package ppt_pkg;

	// Field widths.
	localparam int INDEX_W   = 12;
	localparam int COUNT_W   = 13;
	localparam int CUR_W     = INDEX_W + 3;
	localparam int SIZE_W    = 32;
	localparam int BYTES_W   = 40;
	localparam int PROD_W    = COUNT_W + SIZE_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 40;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Value of the piece size register after reset.
	localparam logic [SIZE_W-1:0] PIECE_SIZE_RESET = 32'd16384;

	// Command codes.
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_SELECT = 3'd3;
	localparam logic [2:0] CMD_LOAD   = 3'd4;
	localparam logic [2:0] CMD_READ   = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PIECE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIECE_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 2'd2;

	// Piece marks: bit 0 received, bit 1 unselected.
	localparam logic [1:0] MARK_CLEAR        = 2'b00;
	localparam logic [1:0] MARK_RECEIVED     = 2'b01;
	localparam logic [1:0] MARK_UNSELECTED   = 2'b10;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RANGE,
		ST_ORDER
	} status_t;

	// Work kinds handed from the front part to the back part.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ADD,
		OP_REMOVE,
		OP_SELECT,
		OP_DESELECT,
		OP_LOAD,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_CALC,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [INDEX_W-1:0] index;
		logic [INDEX_W-1:0] end_index;
		logic               select_value;
		logic [7:0]         byte_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [COUNT_W-1:0] received_count;
		logic [COUNT_W-1:0] selected_count;
		logic [COUNT_W-1:0] selected_received_count;
		logic [BYTES_W-1:0] received_bytes;
		logic [BYTES_W-1:0] selected_received_bytes;
		logic               all_finished;
		logic               selection_finished;
		logic [7:0]         read_byte;
	} result_t;

	// One classified item: the pieces from first up to last_excl are walked.
	typedef struct packed {
		op_t              op;
		status_t          status;
		logic [CUR_W-1:0] first;
		logic [CUR_W-1:0] last_excl;
		logic [7:0]       byte_value;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/ppt_front.sv =====
// Front part: accepts items, checks indexes and turns each into a piece walk.
`default_nettype none

module ppt_front (
	input  ppt_pkg::item_t               item,
	input  logic                         start,
	input  logic [ppt_pkg::COUNT_W-1:0]  n,
	input  logic                         queue_full,
	input  logic                         mod_busy,
	output logic                         busy,
	output logic                         push,
	output ppt_pkg::job_t                job
);
	import ppt_pkg::*;

	logic [CUR_W-1:0] n_w;
	logic [CUR_W-1:0] idx_w;
	logic [CUR_W-1:0] end_w;
	logic [CUR_W-1:0] base_w;
	logic [CUR_W-1:0] base_top;

	// An item is taken whenever the queue has room and the remainder unit is settled.
	assign busy = queue_full | mod_busy;
	assign push = start & ~busy;

	// Classify the command and work out the span of pieces it touches.
	always_comb begin
		n_w      = CUR_W'(n);
		idx_w    = CUR_W'(item.index);
		end_w    = CUR_W'(item.end_index);
		base_w   = {item.index, 3'b000};
		base_top = base_w + CUR_W'(8);
		job      = '{op: OP_NONE, status: ST_OK, first: '0, last_excl: '0,
			byte_value: item.byte_value};
		case (item.cmd)
			CMD_CLEAR: begin
				job.op        = OP_CLEAR;
				job.last_excl = n_w;
			end
			CMD_ADD, CMD_REMOVE: begin
				if (idx_w >= n_w) begin
					job.status = ST_RANGE;
				end else begin
					job.op        = (item.cmd == CMD_ADD) ? OP_ADD : OP_REMOVE;
					job.first     = idx_w;
					job.last_excl = idx_w + CUR_W'(1);
				end
			end
			CMD_SELECT: begin
				if (idx_w >= n_w || end_w >= n_w) begin
					job.status = ST_RANGE;
				end else if (end_w < idx_w) begin
					job.status = ST_ORDER;
				end else begin
					job.op        = item.select_value ? OP_SELECT : OP_DESELECT;
					job.first     = idx_w;
					job.last_excl = end_w + CUR_W'(1);
				end
			end
			CMD_LOAD, CMD_READ: begin
				if (base_w >= n_w) begin
					job.status = ST_RANGE;
				end else begin
					job.op        = (item.cmd == CMD_LOAD) ? OP_LOAD : OP_READ;
					job.first     = base_w;
					job.last_excl = (base_top > n_w) ? n_w : base_top;
				end
			end
			default: begin
				job.op = OP_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ppt_queue.sv =====
// Short queue of classified items between the front and back parts.
`default_nettype none

module ppt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ppt_pkg::job_t push_job,
	input  logic          pop,
	output ppt_pkg::job_t head,
	output logic          empty,
	output logic          full
);
	import ppt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head  = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ppt_mod.sv =====
// Bit-serial remainder unit: total bytes modulo piece size, one bit per cycle.
`default_nettype none

module ppt_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppt_pkg::BYTES_W-1:0]   dividend,
	input  logic [ppt_pkg::SIZE_W-1:0]    divisor,
	output logic                          busy,
	output logic [ppt_pkg::SIZE_W-1:0]    rem
);
	import ppt_pkg::*;

	localparam int STEP_W = $clog2(BYTES_W + 1);

	logic [BYTES_W-1:0] dividend_q;
	logic [SIZE_W-1:0]  divisor_q;
	logic [SIZE_W-1:0]  rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [SIZE_W:0]    trial;
	logic [SIZE_W:0]    diff;

	assign busy = start | (step_q != '0);
	assign rem  = rem_q;

	// Shift the next dividend bit in and subtract the divisor when it fits.
	always_comb begin
		trial = {rem_q, dividend_q[BYTES_W-1]};
		diff  = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			rem_q  <= '0;
		end else if (start) begin
			step_q <= STEP_W'(BYTES_W);
			rem_q  <= '0;
		end else if (step_q != '0) begin
			step_q <= step_q - STEP_W'(1);
			rem_q  <= (trial >= {1'b0, divisor_q}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
		end
	end

	// Operand registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= dividend;
			divisor_q  <= divisor;
		end else if (step_q != '0) begin
			dividend_q <= {dividend_q[BYTES_W-2:0], 1'b0};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ppt_back.sv =====
// Back part: walks the piece mark memory, keeps the counters and builds each result.
`default_nettype none

module ppt_back #(
	parameter int MAX_PIECES = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ppt_pkg::COUNT_W-1:0]  n,
	input  logic                         cfg_clear,
	input  logic                         queue_empty,
	input  ppt_pkg::job_t                job,
	output logic                         pop,
	input  logic [ppt_pkg::SIZE_W-1:0]   piece_size,
	input  logic [ppt_pkg::SIZE_W-1:0]   last_rem,
	input  logic                         mod_busy,
	output logic                         done,
	output ppt_pkg::result_t             result
);
	import ppt_pkg::*;

	localparam int ADDR_W = $clog2(MAX_PIECES);

	back_state_t        state_q;
	back_state_t        state_d;
	job_t               job_q;
	logic               report_q;
	logic               clr_pend_q;
	logic               done_q;
	logic [CUR_W-1:0]   cur_q;
	logic [CUR_W-1:0]   addr_s1;
	logic               rd_s1;
	logic [1:0]         rdata_s1;
	logic [1:0]         marks_mem [MAX_PIECES];
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [1:0]         mem_wdata;
	logic [COUNT_W-1:0] rec_q;
	logic [COUNT_W-1:0] uns_q;
	logic [COUNT_W-1:0] srec_q;
	logic [1:0]         last_mark_q;
	logic [7:0]         rbyte_q;
	logic [PROD_W-1:0]  prod_rec_q;
	logic [PROD_W-1:0]  prod_srec_q;
	logic               add_rec_q;
	logic               add_srec_q;
	logic               issue;
	logic               walk_done;
	logic               is_last_s1;
	logic               upd_s1;
	logic [1:0]         new_mark;
	logic               last_rec;
	logic               last_srec;
	logic [COUNT_W-1:0] full_rec;
	logic [COUNT_W-1:0] full_srec;
	logic [COUNT_W-1:0] selected;
	logic [SIZE_W-1:0]  last_len;
	logic               bytes_zero;

	// Saturate a byte sum to the result width, or force it to zero.
	function automatic logic [BYTES_W-1:0] sat_bytes(input logic [SUM_W-1:0] sum,
			input logic zero);
		logic [BYTES_W-1:0] r;
		if (zero) begin
			r = '0;
		end else if (sum[SUM_W-1:BYTES_W] != '0) begin
			r = '1;
		end else begin
			r = sum[BYTES_W-1:0];
		end
		return r;
	endfunction

	assign done   = done_q;
	assign pop    = (state_q == B_IDLE) && !clr_pend_q && !queue_empty;

	// Walk control: one piece address goes out per cycle, its mark returns in the next cycle.
	assign issue      = (state_q == B_WALK) && (cur_q < job_q.last_excl);
	assign walk_done  = !issue && !rd_s1;
	assign is_last_s1 = (n != '0) && (addr_s1 == CUR_W'(n) - CUR_W'(1));
	assign upd_s1     = rd_s1 && (job_q.op != OP_READ);

	// New mark of the piece that has just been read.
	always_comb begin
		case (job_q.op)
			OP_ADD:      new_mark = rdata_s1 | MARK_RECEIVED;
			OP_REMOVE:   new_mark = rdata_s1 & MARK_UNSELECTED;
			OP_SELECT:   new_mark = rdata_s1 & MARK_RECEIVED;
			OP_DESELECT: new_mark = rdata_s1 | MARK_UNSELECTED;
			OP_LOAD:     new_mark = job_q.byte_value[3'(3'd7 - addr_s1[2:0])] ?
				MARK_RECEIVED : MARK_CLEAR;
			default:     new_mark = rdata_s1;
		endcase
	end

	// Memory port selection: a clear writes straight from the cursor.
	always_comb begin
		mem_raddr = ADDR_W'(cur_q);
		if (job_q.op == OP_CLEAR) begin
			mem_we    = issue;
			mem_waddr = ADDR_W'(cur_q);
			mem_wdata = MARK_CLEAR;
		end else begin
			mem_we    = upd_s1;
			mem_waddr = ADDR_W'(addr_s1);
			mem_wdata = new_mark;
		end
	end

	// Mark memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			marks_mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= marks_mem[mem_raddr];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (clr_pend_q || !queue_empty) begin
					state_d = B_WALK;
				end
			end
			B_WALK: begin
				if (walk_done) begin
					state_d = report_q ? B_CALC : B_IDLE;
				end
			end
			B_CALC: begin
				if (!mod_busy) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_pend_q  <= 1'b0;
			report_q    <= 1'b0;
			rd_s1       <= 1'b0;
			done_q      <= 1'b0;
			rec_q       <= '0;
			uns_q       <= '0;
			srec_q      <= '0;
			last_mark_q <= MARK_CLEAR;
		end else begin
			done_q <= (state_q == B_OUT);
			rd_s1  <= issue && (job_q.op != OP_CLEAR);
			if (state_q == B_IDLE) begin
				if (clr_pend_q) begin
					clr_pend_q  <= 1'b0;
					report_q    <= 1'b0;
					rec_q       <= '0;
					uns_q       <= '0;
					srec_q      <= '0;
					last_mark_q <= MARK_CLEAR;
				end else if (!queue_empty) begin
					report_q <= 1'b1;
					if (job.op == OP_CLEAR) begin
						rec_q       <= '0;
						uns_q       <= '0;
						srec_q      <= '0;
						last_mark_q <= MARK_CLEAR;
					end
				end
			end
			if (upd_s1) begin
				rec_q  <= rec_q - COUNT_W'(rdata_s1[0]) + COUNT_W'(new_mark[0]);
				uns_q  <= uns_q - COUNT_W'(rdata_s1[1]) + COUNT_W'(new_mark[1]);
				srec_q <= srec_q - COUNT_W'(rdata_s1 == MARK_RECEIVED)
					+ COUNT_W'(new_mark == MARK_RECEIVED);
				if (is_last_s1) begin
					last_mark_q <= new_mark;
				end
			end
			if (cfg_clear) begin
				clr_pend_q <= 1'b1;
			end
		end
	end

	// Terms for the byte totals.
	always_comb begin
		last_rec   = (n != '0) && last_mark_q[0];
		last_srec  = (n != '0) && (last_mark_q == MARK_RECEIVED);
		full_rec   = (last_rec && rec_q != '0) ? rec_q - COUNT_W'(1) : rec_q;
		full_srec  = (last_srec && srec_q != '0) ? srec_q - COUNT_W'(1) : srec_q;
		selected   = (n >= uns_q) ? n - uns_q : '0;
		last_len   = (last_rem == '0) ? piece_size : last_rem;
		bytes_zero = (n == '0) || (piece_size == '0);
	end

	// Item payload, read byte, products and the result register.
	always_ff @(posedge clk) begin
		addr_s1 <= cur_q;
		if (state_q == B_IDLE) begin
			rbyte_q <= '0;
			if (clr_pend_q) begin
				job_q <= '{op: OP_CLEAR, status: ST_OK, first: '0,
					last_excl: CUR_W'(n), byte_value: '0};
				cur_q <= '0;
			end else if (!queue_empty) begin
				job_q <= job;
				cur_q <= job.first;
			end
		end else if (issue) begin
			cur_q <= cur_q + CUR_W'(1);
		end
		if (rd_s1 && job_q.op == OP_READ && rdata_s1[0]) begin
			rbyte_q[3'(3'd7 - addr_s1[2:0])] <= 1'b1;
		end
		if (state_q == B_CALC) begin
			prod_rec_q  <= PROD_W'(full_rec) * PROD_W'(piece_size);
			prod_srec_q <= PROD_W'(full_srec) * PROD_W'(piece_size);
			add_rec_q   <= last_rec && rec_q != '0;
			add_srec_q  <= last_srec && srec_q != '0;
		end
		if (state_q == B_OUT) begin
			result.status                  <= job_q.status;
			result.received_count          <= rec_q;
			result.selected_count          <= selected;
			result.selected_received_count <= srec_q;
			result.received_bytes          <= sat_bytes(SUM_W'(prod_rec_q)
				+ (add_rec_q ? SUM_W'(last_len) : SUM_W'(0)), bytes_zero);
			result.selected_received_bytes <= sat_bytes(SUM_W'(prod_srec_q)
				+ (add_srec_q ? SUM_W'(last_len) : SUM_W'(0)), bytes_zero);
			result.all_finished            <= (n != '0) && (rec_q == n);
			result.selection_finished      <= (n != '0) && (srec_q == selected);
			result.read_byte               <= rbyte_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/piece_progress_tracker_top.sv =====
// Top level of the piece progress tracker: configuration registers and the four parts.
`default_nettype none

// An item is taken when start is high and busy is low; its result appears on result for
// one cycle with done high and cannot be held off. The back part walks the piece mark
// memory at one piece per cycle, reading one mark while writing back the one before. An
// item touches one piece for add and remove, end minus start plus one for a range, and up
// to eight for a byte load or read; a clear walks all pieces in use, and a rejected or
// unused command none. While the back part works, the front part keeps taking items into
// a two-entry queue. Writing the piece count clears the marks of all pieces in use;
// writing the piece size or total bytes starts a remainder computation that keeps busy
// high while it runs. Marks above the piece count are never read, so no clearing runs
// after reset.
module piece_progress_tracker_top #(
	parameter int MAX_PIECES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  ppt_pkg::item_t                  item,
	output logic                            done,
	output ppt_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ppt_pkg::*;

	localparam int CAP = (MAX_PIECES > 8191) ? 8191 : MAX_PIECES;

	logic [COUNT_W-1:0] piece_count_q;
	logic [SIZE_W-1:0]  piece_size_q;
	logic [BYTES_W-1:0] total_bytes_q;
	logic               mod_start_q;
	logic               cfg_write;
	logic               cfg_clear;
	logic [COUNT_W-1:0] n;
	logic               mod_busy;
	logic [SIZE_W-1:0]  last_rem;
	logic               push;
	logic               pop;
	logic               queue_full;
	logic               queue_empty;
	job_t               push_job;
	job_t               head_job;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;
	assign cfg_clear = cfg_write && (cfg_index == REG_PIECE_COUNT);

	// Pieces in use, bounded by the mark memory depth.
	assign n = (piece_count_q > COUNT_W'(CAP)) ? COUNT_W'(CAP) : piece_count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_count_q <= '0;
			piece_size_q  <= PIECE_SIZE_RESET;
			total_bytes_q <= '0;
			mod_start_q   <= 1'b0;
		end else begin
			mod_start_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					REG_PIECE_COUNT: begin
						piece_count_q <= cfg_data[COUNT_W-1:0];
					end
					REG_PIECE_SIZE: begin
						piece_size_q <= cfg_data[SIZE_W-1:0];
						mod_start_q  <= 1'b1;
					end
					REG_TOTAL_BYTES: begin
						total_bytes_q <= cfg_data[BYTES_W-1:0];
						mod_start_q   <= 1'b1;
					end
					default: begin
						mod_start_q <= 1'b0;
					end
				endcase
			end
		end
	end

	ppt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start_q),
		.dividend (total_bytes_q),
		.divisor  (piece_size_q),
		.busy     (mod_busy),
		.rem      (last_rem)
	);

	ppt_front u_front (
		.item       (item),
		.start      (start),
		.n          (n),
		.queue_full (queue_full),
		.mod_busy   (mod_busy),
		.busy       (busy),
		.push       (push),
		.job        (push_job)
	);

	ppt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head_job),
		.empty    (queue_empty),
		.full     (queue_full)
	);

	ppt_back #(
		.MAX_PIECES (MAX_PIECES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.n           (n),
		.cfg_clear   (cfg_clear),
		.queue_empty (queue_empty),
		.job         (head_job),
		.pop         (pop),
		.piece_size  (piece_size_q),
		.last_rem    (last_rem),
		.mod_busy    (mod_busy),
		.done        (done),
		.result      (result)
	);

	// A result strobe never repeats back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// The front part never pushes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("push into full queue");

	// Selected received pieces are a subset of received pieces.
	a_srec_le_rec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.selected_received_count <= result.received_count))
		else $error("selected received count above received count");

	// No item is taken while the remainder is being recomputed.
	a_busy_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_busy |-> busy)
		else $error("item accepted during remainder computation");

endmodule

`default_nettype wire
